>>> src/pkx_pkg.sv
// Package: constants and types shared by the port key extractor.
`timescale 1ns / 1ps
package pkx_pkg;

  localparam int unsigned IdentIndexBits = 16;
  localparam int unsigned KeyW           = 16;
  localparam int unsigned InDataW        = 120;
  localparam int unsigned OutDataW       = 32;

  localparam logic [7:0] ProtoIcmp = 8'd1;
  localparam logic [7:0] ProtoTcp  = 8'd6;
  localparam logic [7:0] ProtoUdp  = 8'd17;

  localparam logic [7:0] IcmpEchoReply   = 8'd0;
  localparam logic [7:0] IcmpEchoRequest = 8'd8;

  typedef struct packed {
    logic [7:0]  l4_protocol;
    logic        more_fragments;
    logic [12:0] fragment_offset;
    logic [15:0] ip_ident;
    logic [15:0] l4_src_port;
    logic [15:0] l4_dst_port;
    logic [7:0]  icmp_type;
    logic [15:0] icmp_ident;
    logic [7:0]  inner_protocol;
    logic [15:0] inner_src_port;
  } pkx_hdr_t;

  typedef struct packed {
    logic [KeyW-1:0] dst_key;
    logic [KeyW-1:0] src_key;
    logic            mem_rd;
    logic            mem_wr;
  } pkx_key_t;

endpackage

>>> src/pkx_key_calc.sv
// Key selection: derives both port keys and fragment table actions for one header.
`timescale 1ns / 1ps
module pkx_key_calc (
  input  logic              is_send_i,
  input  pkx_pkg::pkx_hdr_t hdr_i,
  output pkx_pkg::pkx_key_t key_o
);

  logic tcp_udp;
  logic icmp;
  logic echo;
  logic inner_tcp_udp;
  logic first_frag;

  always_comb begin
    tcp_udp       = (hdr_i.l4_protocol == pkx_pkg::ProtoTcp) ||
                    (hdr_i.l4_protocol == pkx_pkg::ProtoUdp);
    icmp          = (hdr_i.l4_protocol == pkx_pkg::ProtoIcmp);
    echo          = (hdr_i.icmp_type == pkx_pkg::IcmpEchoReply) ||
                    (hdr_i.icmp_type == pkx_pkg::IcmpEchoRequest);
    inner_tcp_udp = (hdr_i.inner_protocol == pkx_pkg::ProtoTcp) ||
                    (hdr_i.inner_protocol == pkx_pkg::ProtoUdp);
    first_frag    = (hdr_i.fragment_offset == 13'd0);

    key_o.dst_key = '0;
    if (tcp_udp) begin
      key_o.dst_key = hdr_i.l4_dst_port;
    end else if (!is_send_i && icmp) begin
      if (echo) begin
        key_o.dst_key = hdr_i.icmp_ident;
      end else if (inner_tcp_udp) begin
        key_o.dst_key = hdr_i.inner_src_port;
      end
    end

    key_o.src_key = '0;
    if (tcp_udp) begin
      key_o.src_key = hdr_i.l4_src_port;
    end else if (is_send_i && icmp && echo) begin
      key_o.src_key = hdr_i.icmp_ident;
    end

    key_o.mem_rd = !is_send_i && !first_frag;
    key_o.mem_wr = !is_send_i && first_frag && hdr_i.more_fragments;
  end

endmodule

>>> src/pkx_frag_mem.sv
// Fragment key table: one write and one registered read port, zeroed by a sweep after reset.
`timescale 1ns / 1ps
module pkx_frag_mem #(
  parameter int unsigned IdentIndexBits = pkx_pkg::IdentIndexBits
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      rd_en_i,
  input  logic [IdentIndexBits-1:0] rd_addr_i,
  output logic [pkx_pkg::KeyW-1:0]  rd_data_o,
  input  logic                      wr_en_i,
  input  logic [IdentIndexBits-1:0] wr_addr_i,
  input  logic [pkx_pkg::KeyW-1:0]  wr_data_i,
  output logic                      busy_o
);

  localparam int unsigned Depth = 2 ** IdentIndexBits;

  logic [pkx_pkg::KeyW-1:0]  mem [Depth];
  logic                      busy_q, busy_d;
  logic [IdentIndexBits-1:0] clr_idx_q, clr_idx_d;
  logic                      we;
  logic [IdentIndexBits-1:0] wa;
  logic [pkx_pkg::KeyW-1:0]  wd;
  logic [pkx_pkg::KeyW-1:0]  rd_data_q;

  always_comb begin
    busy_d    = busy_q;
    clr_idx_d = clr_idx_q;
    if (busy_q) begin
      clr_idx_d = clr_idx_q + 1'b1;
      if (&clr_idx_q) begin
        busy_d = 1'b0;
      end
    end
    we = busy_q || wr_en_i;
    wa = busy_q ? clr_idx_q : wr_addr_i;
    wd = busy_q ? '0 : wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b1;
      clr_idx_q <= '0;
    end else begin
      busy_q    <= busy_d;
      clr_idx_q <= clr_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;
  assign busy_o    = busy_q;

endmodule

>>> src/port_key_extractor_with_fragment_cache.sv
// Top level: port key extractor with a fragment key table indexed by IP identification.
// An accepted beat passes the input then the output stage; all stages advance together.
// Throughput: one beat per cycle when the output is free and the table is not clearing.
// Reset: asynchronous, active low; afterwards the 2**IdentIndexBits table entries
// (65536 by default) are zeroed one entry per cycle, with s_axis_tready_o held low.
// The fragment table read port sets the second stage: stored keys appear in the cycle after the read.
`timescale 1ns / 1ps
module port_key_extractor_with_fragment_cache #(
  parameter int unsigned IdentIndexBits = pkx_pkg::IdentIndexBits
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  // l4_protocol[7:0], more_fragments[8], fragment_offset[21:9], ip_ident[37:22],
  // l4_src_port[53:38], l4_dst_port[69:54], icmp_type[77:70], icmp_ident[93:78],
  // inner_protocol[101:94], inner_src_port[117:102], zero[119:118]
  input  logic [pkx_pkg::InDataW-1:0]  s_axis_tdata_i,
  // is_send[0]
  input  logic                         s_axis_tuser_i,
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  // dst_key[15:0], src_key[31:16]
  output logic [pkx_pkg::OutDataW-1:0] m_axis_tdata_o
);

  logic                      adv;
  logic                      busy;
  logic                      in_valid_q;
  logic [117:0]              in_data_q;
  logic                      in_send_q;
  pkx_pkg::pkx_hdr_t         hdr;
  pkx_pkg::pkx_key_t         key;
  logic                      out_valid_q;
  logic                      out_rd_q;
  logic [pkx_pkg::KeyW-1:0]  out_dst_q;
  logic [pkx_pkg::KeyW-1:0]  out_src_q;
  logic [pkx_pkg::KeyW-1:0]  rd_data;
  logic [IdentIndexBits-1:0] slot;

  assign adv             = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = adv && !busy;

  always_comb begin
    hdr.l4_protocol     = in_data_q[7:0];
    hdr.more_fragments  = in_data_q[8];
    hdr.fragment_offset = in_data_q[21:9];
    hdr.ip_ident        = in_data_q[37:22];
    hdr.l4_src_port     = in_data_q[53:38];
    hdr.l4_dst_port     = in_data_q[69:54];
    hdr.icmp_type       = in_data_q[77:70];
    hdr.icmp_ident      = in_data_q[93:78];
    hdr.inner_protocol  = in_data_q[101:94];
    hdr.inner_src_port  = in_data_q[117:102];
    slot                = hdr.ip_ident[IdentIndexBits-1:0];
  end

  pkx_key_calc u_key_calc (
    .is_send_i (in_send_q),
    .hdr_i     (hdr),
    .key_o     (key)
  );

  pkx_frag_mem #(
    .IdentIndexBits (IdentIndexBits)
  ) u_frag_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (adv && in_valid_q && key.mem_rd),
    .rd_addr_i (slot),
    .rd_data_o (rd_data),
    .wr_en_i   (adv && in_valid_q && key.mem_wr),
    .wr_addr_i (slot),
    .wr_data_i (key.dst_key),
    .busy_o    (busy)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      in_valid_q  <= s_axis_tvalid_i && s_axis_tready_o;
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      in_data_q <= s_axis_tdata_i[117:0];
      in_send_q <= s_axis_tuser_i;
      out_rd_q  <= key.mem_rd;
      out_dst_q <= key.dst_key;
      out_src_q <= key.src_key;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_src_q, out_rd_q ? rd_data : out_dst_q};

  a_no_accept_while_clearing : assert property (
    @(posedge clk_i) disable iff (!rst_ni) busy |-> !s_axis_tready_o
  ) else $error("input accepted during table clear");

  a_no_output_while_clearing : assert property (
    @(posedge clk_i) disable iff (!rst_ni) busy |-> !m_axis_tvalid_o && !in_valid_q
  ) else $error("pipeline active during table clear");

  a_stage_holds_on_stall : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !adv |=> in_valid_q && $stable(in_data_q)
  ) else $error("input stage changed while stalled");

  a_rd_wr_exclusive : assert property (
    @(posedge clk_i) disable iff (!rst_ni) in_valid_q |-> !(key.mem_rd && key.mem_wr)
  ) else $error("fragment table read and write from one beat");

endmodule
